// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RPF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define RPF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/rpf_pkg.sv =====
`timescale 1ns / 1ps

package rpf_pkg;

   // Word length compared per distance and the score a local search needs.
   localparam int WORD_LEN     = 8;
   localparam int NEED_SCORE   = 6;
   localparam int WIDE_RANGE   = 6;
   localparam int NARROW_RANGE = 2;

   // Consensus tracking.
   localparam int STRENGTH_NEW = 10;
   localparam int STRENGTH_MAX = 15;
   localparam int STRENGTH_MIN = -1;
   localparam int PERIOD_RESET = 200;
   localparam int MINP_RESET   = 200;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_REF_RD,
      ST_REF_CAP,
      ST_CONS,
      ST_LSTEP,
      ST_TRY,
      ST_RD,
      ST_CMP,
      ST_DONE,
      ST_LDONE,
      ST_RAISE,
      ST_MOD,
      ST_DIV3,
      ST_SNAP2,
      ST_SNAP3,
      ST_UPD
   } rpf_state_type;

   typedef enum logic [1:0] {
      PH_CONS,
      PH_TWO,
      PH_THREE,
      PH_EXACT
   } rpf_phase_type;

   // Search result handed from the sequencer to the output stage.
   typedef struct packed {
      logic       done;
      logic       found;
      logic [8:0] period;
   } rpf_result_type;

endpackage

// ===== hdl/rpf_hist.sv =====
`timescale 1ns / 1ps

module rpf_hist #(
   parameter int DEPTH = 260,
   parameter int OW    = 10
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [7:0]    wr_data,
   input  logic [OW-1:0] rd_off,
   output logic [7:0]    rd_data
);

   localparam int AW = $clog2(DEPTH);

   logic [7:0]    mem [DEPTH];
   logic [AW-1:0] wr_slot_ff;
   logic [AW-1:0] wr_slot_in;
   logic [OW:0]   sum;
   logic [OW:0]   wrapped;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data_ff;

   // Write pointer walks the ring; once the ring is full it points at the oldest item.
   always_comb begin
      if (wr_slot_ff == AW'(DEPTH - 1)) begin
         wr_slot_in = '0;
      end else begin
         wr_slot_in = wr_slot_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_slot_ff <= '0;
      end else if (wr_en) begin
         wr_slot_ff <= wr_slot_in;
      end
   end

   // Offsets count from the oldest item; one subtract folds the sum into the ring.
   always_comb begin
      sum = (OW + 1)'(wr_slot_ff) + (OW + 1)'(rd_off);
      if (sum >= (OW + 1)'(DEPTH)) begin
         wrapped = sum - (OW + 1)'(DEPTH);
      end else begin
         wrapped = sum;
      end
      rd_addr = wrapped[AW-1:0];
   end

   // Single write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_slot_ff] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/rpf_ctrl.sv =====
`timescale 1ns / 1ps

module rpf_ctrl #(
   parameter int MAX_PERIOD = 250,
   parameter int DW         = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [7:0]              minp,
   output logic [DW-1:0]           rd_off,
   input  logic [7:0]              rd_data,
   output rpf_pkg::rpf_result_type result
);

   localparam logic [DW-1:0] MAX_D = DW'(MAX_PERIOD);
   localparam logic [DW-1:0] ONE_D = DW'(1);
   localparam logic [DW-1:0] TWO_D = DW'(2);
   localparam logic [DW-1:0] THR_D = DW'(3);

   rpf_pkg::rpf_state_type state_ff, state_in;
   rpf_pkg::rpf_phase_type phase_ff, phase_in;

   logic [7:0]        ref_ff [rpf_pkg::WORD_LEN];
   logic [7:0]        ref_in [rpf_pkg::WORD_LEN];
   logic [2:0]        l_ff, l_in;
   logic [3:0]        score_ff, score_in;
   logic [DW-1:0]     cand_ff, cand_in;
   logic [DW-1:0]     start_ff, start_in;
   logic [2:0]        range_ff, range_in;
   logic [2:0]        k_ff, k_in;
   logic              side_ff, side_in;
   logic [3:0]        best_ff, best_in;
   logic [DW-1:0]     bestd_ff, bestd_in;
   logic [DW-1:0]     d_ff, d_in;
   logic [DW-1:0]     base_ff, base_in;
   logic [DW-1:0]     r_ff, r_in;
   logic [DW-1:0]     q_ff, q_in;
   logic [8:0]        cons_ff, cons_in;
   logic signed [4:0] str_ff, str_in;

   logic [DW-1:0]     minp_d;
   logic [DW-1:0]     cons_d;
   logic              cand_ok;
   logic              lstep_go;
   logic              match;
   logic [DW-1:0]     loc_res;
   logic [DW-1:0]     half;
   logic              exact_ok;
   logic              neq;
   logic signed [4:0] s1;

   // Decisions used by the next-state, strength and datapath logic.
   always_comb begin
      minp_d   = DW'(minp);
      cons_d   = DW'(cons_ff);
      cand_ok  = (cand_ff >= ONE_D) && (cand_ff <= MAX_D);
      lstep_go = (k_ff <= range_ff) && (start_ff >= DW'(k_ff) + TWO_D);
      match    = (rd_data == ref_ff[l_ff]);
      loc_res  = (best_ff >= 4'(rpf_pkg::NEED_SCORE)) ? bestd_ff : '0;
      half     = d_ff >> 1;
      exact_ok = (minp_d <= MAX_D);
      neq      = (d_ff != cons_d);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rpf_pkg::ST_IDLE: begin
            if (start) begin
               state_in = rpf_pkg::ST_REF_RD;
            end
         end
         rpf_pkg::ST_REF_RD: state_in = rpf_pkg::ST_REF_CAP;
         rpf_pkg::ST_REF_CAP: begin
            if (l_ff == 3'(rpf_pkg::WORD_LEN - 1)) begin
               state_in = rpf_pkg::ST_CONS;
            end else begin
               state_in = rpf_pkg::ST_REF_RD;
            end
         end
         rpf_pkg::ST_CONS: begin
            if (str_ff > 5'sd0) begin
               state_in = rpf_pkg::ST_LSTEP;
            end else if (exact_ok) begin
               state_in = rpf_pkg::ST_TRY;
            end else begin
               state_in = rpf_pkg::ST_UPD;
            end
         end
         rpf_pkg::ST_LSTEP: begin
            if (lstep_go) begin
               state_in = rpf_pkg::ST_TRY;
            end else begin
               state_in = rpf_pkg::ST_LDONE;
            end
         end
         rpf_pkg::ST_TRY: begin
            if (cand_ok) begin
               state_in = rpf_pkg::ST_RD;
            end else begin
               state_in = rpf_pkg::ST_DONE;
            end
         end
         rpf_pkg::ST_RD: state_in = rpf_pkg::ST_CMP;
         rpf_pkg::ST_CMP: begin
            if ((phase_ff == rpf_pkg::PH_EXACT && !match) ||
                l_ff == 3'(rpf_pkg::WORD_LEN - 1)) begin
               state_in = rpf_pkg::ST_DONE;
            end else begin
               state_in = rpf_pkg::ST_RD;
            end
         end
         rpf_pkg::ST_DONE: begin
            if (phase_ff == rpf_pkg::PH_EXACT) begin
               if (score_ff == 4'(rpf_pkg::WORD_LEN)) begin
                  state_in = rpf_pkg::ST_RAISE;
               end else if (cand_ff == MAX_D) begin
                  state_in = rpf_pkg::ST_UPD;
               end else begin
                  state_in = rpf_pkg::ST_TRY;
               end
            end else if (!side_ff) begin
               state_in = rpf_pkg::ST_TRY;
            end else begin
               state_in = rpf_pkg::ST_LSTEP;
            end
         end
         rpf_pkg::ST_LDONE: begin
            unique case (phase_ff)
               rpf_pkg::PH_CONS: begin
                  if (loc_res != '0) begin
                     state_in = rpf_pkg::ST_RAISE;
                  end else if (exact_ok) begin
                     state_in = rpf_pkg::ST_TRY;
                  end else begin
                     state_in = rpf_pkg::ST_UPD;
                  end
               end
               rpf_pkg::PH_TWO: begin
                  if (loc_res != '0) begin
                     state_in = rpf_pkg::ST_UPD;
                  end else begin
                     state_in = rpf_pkg::ST_SNAP3;
                  end
               end
               default: state_in = rpf_pkg::ST_UPD;
            endcase
         end
         rpf_pkg::ST_RAISE: begin
            if (d_ff >= minp_d) begin
               state_in = rpf_pkg::ST_MOD;
            end
         end
         rpf_pkg::ST_MOD: begin
            if (cons_ff == '0 || r_ff < cons_d) begin
               if (cons_ff != '0 && r_ff == '0) begin
                  state_in = rpf_pkg::ST_UPD;
               end else begin
                  state_in = rpf_pkg::ST_DIV3;
               end
            end
         end
         rpf_pkg::ST_DIV3: begin
            if (r_ff < THR_D) begin
               state_in = rpf_pkg::ST_SNAP2;
            end
         end
         rpf_pkg::ST_SNAP2: begin
            if (half >= minp_d) begin
               state_in = rpf_pkg::ST_LSTEP;
            end else begin
               state_in = rpf_pkg::ST_SNAP3;
            end
         end
         rpf_pkg::ST_SNAP3: begin
            if (q_ff >= minp_d) begin
               state_in = rpf_pkg::ST_LSTEP;
            end else begin
               state_in = rpf_pkg::ST_UPD;
            end
         end
         rpf_pkg::ST_UPD: state_in = rpf_pkg::ST_IDLE;
         default: state_in = rpf_pkg::ST_IDLE;
      endcase
   end

   // Outputs: memory offset and the finished result.
   always_comb begin
      rd_off        = '0;
      result.done   = 1'b0;
      result.found  = 1'b0;
      result.period = d_ff[8:0];
      unique case (state_ff)
         rpf_pkg::ST_REF_RD: rd_off = DW'(l_ff);
         rpf_pkg::ST_RD:     rd_off = cand_ff + DW'(l_ff);
         rpf_pkg::ST_UPD: begin
            result.done  = 1'b1;
            result.found = (d_ff != '0);
         end
         default: rd_off = '0;
      endcase
   end

   // Consensus strength after this position.
   always_comb begin
      s1 = str_ff;
      if (neq) begin
         if (str_ff != 5'(rpf_pkg::STRENGTH_MIN)) begin
            s1 = str_ff - 5'sd1;
         end
      end
   end

   // Datapath: all working registers are updated here.
   always_comb begin
      phase_in = phase_ff;
      ref_in   = ref_ff;
      l_in     = l_ff;
      score_in = score_ff;
      cand_in  = cand_ff;
      start_in = start_ff;
      range_in = range_ff;
      k_in     = k_ff;
      side_in  = side_ff;
      best_in  = best_ff;
      bestd_in = bestd_ff;
      d_in     = d_ff;
      base_in  = base_ff;
      r_in     = r_ff;
      q_in     = q_ff;
      cons_in  = cons_ff;
      str_in   = str_ff;
      case (state_ff)
         rpf_pkg::ST_IDLE: begin
            l_in = '0;
            d_in = '0;
         end
         rpf_pkg::ST_REF_CAP: begin
            ref_in[l_ff] = rd_data;
            l_in         = l_ff + 3'd1;
         end
         rpf_pkg::ST_CONS: begin
            if (str_ff > 5'sd0) begin
               phase_in = rpf_pkg::PH_CONS;
               start_in = cons_d;
               range_in = 3'(rpf_pkg::WIDE_RANGE);
               k_in     = '0;
               best_in  = '0;
               bestd_in = '0;
            end else begin
               phase_in = rpf_pkg::PH_EXACT;
               cand_in  = minp_d;
            end
         end
         rpf_pkg::ST_LSTEP: begin
            cand_in = start_ff + DW'(k_ff);
            side_in = 1'b0;
         end
         rpf_pkg::ST_TRY: begin
            l_in     = '0;
            score_in = '0;
         end
         rpf_pkg::ST_CMP: begin
            if (match) begin
               score_in = score_ff + 4'd1;
            end
            l_in = l_ff + 3'd1;
         end
         rpf_pkg::ST_DONE: begin
            if (phase_ff == rpf_pkg::PH_EXACT) begin
               if (score_ff == 4'(rpf_pkg::WORD_LEN)) begin
                  d_in    = cand_ff;
                  base_in = cand_ff;
               end else begin
                  cand_in = cand_ff + ONE_D;
               end
            end else begin
               if (score_ff > best_ff) begin
                  best_in  = score_ff;
                  bestd_in = cand_ff;
               end
               if (!side_ff) begin
                  side_in = 1'b1;
                  cand_in = start_ff - DW'(k_ff) - ONE_D;
               end else begin
                  k_in = k_ff + 3'd1;
               end
            end
         end
         rpf_pkg::ST_LDONE: begin
            if (loc_res != '0) begin
               d_in    = loc_res;
               base_in = loc_res;
            end else if (phase_ff == rpf_pkg::PH_CONS) begin
               phase_in = rpf_pkg::PH_EXACT;
               cand_in  = minp_d;
            end
         end
         rpf_pkg::ST_RAISE: begin
            if (d_ff < minp_d) begin
               d_in = d_ff + base_ff;
            end else begin
               r_in = d_ff;
            end
         end
         rpf_pkg::ST_MOD: begin
            if (cons_ff != '0 && r_ff >= cons_d) begin
               r_in = r_ff - cons_d;
            end else if (cons_ff != '0 && r_ff == '0) begin
               d_in = cons_d;
            end else begin
               r_in = d_ff;
               q_in = '0;
            end
         end
         rpf_pkg::ST_DIV3: begin
            if (r_ff >= THR_D) begin
               r_in = r_ff - THR_D;
               q_in = q_ff + ONE_D;
            end
         end
         rpf_pkg::ST_SNAP2: begin
            phase_in = rpf_pkg::PH_TWO;
            start_in = half;
            range_in = 3'(rpf_pkg::NARROW_RANGE);
            k_in     = '0;
            best_in  = '0;
            bestd_in = '0;
         end
         rpf_pkg::ST_SNAP3: begin
            phase_in = rpf_pkg::PH_THREE;
            start_in = q_ff;
            range_in = 3'(rpf_pkg::NARROW_RANGE);
            k_in     = '0;
            best_in  = '0;
            bestd_in = '0;
         end
         rpf_pkg::ST_UPD: begin
            str_in = s1;
            if (d_ff != '0) begin
               if (!neq && s1 < 5'(rpf_pkg::STRENGTH_MAX)) begin
                  str_in = s1 + 5'sd1;
               end
               if (str_in <= 5'sd0) begin
                  cons_in = d_ff[8:0];
                  str_in  = 5'(rpf_pkg::STRENGTH_NEW);
               end
            end
         end
         default: l_in = l_ff;
      endcase
   end

   // Control state and consensus are reset; the working registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpf_pkg::ST_IDLE;
         phase_ff <= rpf_pkg::PH_CONS;
         cons_ff  <= 9'(rpf_pkg::PERIOD_RESET);
         str_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         cons_ff  <= cons_in;
         str_ff   <= str_in;
      end
   end

   always_ff @(posedge clock) begin
      ref_ff   <= ref_in;
      l_ff     <= l_in;
      score_ff <= score_in;
      cand_ff  <= cand_in;
      start_ff <= start_in;
      range_ff <= range_in;
      k_ff     <= k_in;
      side_ff  <= side_in;
      best_ff  <= best_in;
      bestd_ff <= bestd_in;
      d_ff     <= d_in;
      base_ff  <= base_in;
      r_ff     <= r_in;
      q_ff     <= q_in;
   end

endmodule

// ===== hdl/repeat_period_finder.sv =====
// Search: the reference word is read, then a local search around the consensus or exact
// distances from min_period upward, each distance compared symbol by symbol, then the
// raise, modulo and divide-by-three loops and snap decisions, one step a cycle.
// Throughput: one symbol at a time; the next is taken once the link has been taken, or
// the cycle after the search when there is no link; warm-up symbols are never stalled.
// Reset: synchronous, active high; counters, strength cleared; consensus, min_period 200.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module repeat_period_finder #(
   parameter int MAX_PERIOD = 250
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_symbol,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_link_start,
   output logic [8:0]  rsp_link_period,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   localparam int DEPTH = MAX_PERIOD + 10;
   localparam int DW    = $clog2(MAX_PERIOD + 520);
   localparam int FW    = $clog2(DEPTH + 1);

   logic                    accept;
   logic                    start;
   logic [7:0]              minp_ff;
   logic [7:0]              minp_eff;
   logic [31:0]             count_ff;
   logic [FW-1:0]           fill_ff;
   logic [31:0]             pos_ff;
   logic                    busy_ff;
   logic                    rsp_valid_ff;
   logic [31:0]             rsp_start_ff;
   logic [8:0]              rsp_period_ff;
   logic [DW-1:0]           rd_off;
   logic [7:0]              rd_data;
   rpf_pkg::rpf_result_type result;

   assign req_stall = busy_ff | rsp_valid_ff;
   assign accept    = req_valid & ~req_stall;
   assign start     = accept && (fill_ff >= FW'(DEPTH - 1));
   assign minp_eff  = (minp_ff == '0) ? 8'd1 : minp_ff;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         minp_ff <= 8'(rpf_pkg::MINP_RESET);
      end else if (csr_write_enable) begin
         minp_ff <= csr_write_data;
      end
   end

   // Item count, window fill and the position examined for this item.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fill_ff  <= '0;
      end else if (accept) begin
         count_ff <= count_ff + 32'd1;
         if (fill_ff < FW'(DEPTH)) begin
            fill_ff <= fill_ff + FW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pos_ff <= count_ff - 32'(DEPTH - 1);
      end
   end

   // Busy flag and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (start) begin
            busy_ff <= 1'b1;
         end else if (result.done) begin
            busy_ff <= 1'b0;
         end
         if (result.done && result.found) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (result.done && result.found) begin
         rsp_start_ff  <= pos_ff;
         rsp_period_ff <= result.period;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_link_start  = rsp_start_ff;
   assign rsp_link_period = rsp_period_ff;

   rpf_hist #(
      .DEPTH (DEPTH),
      .OW    (DW)
   ) u_hist (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_data (req_symbol),
      .rd_off  (rd_off),
      .rd_data (rd_data)
   );

   rpf_ctrl #(
      .MAX_PERIOD (MAX_PERIOD),
      .DW         (DW)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .minp    (minp_eff),
      .rd_off  (rd_off),
      .rd_data (rd_data),
      .result  (result)
   );

   `RPF_ASSERT_NOW(a_done_while_busy, clock, reset, result.done, busy_ff)
   `RPF_ASSERT_NOW(a_rsp_not_busy, clock, reset, rsp_valid_ff, !busy_ff)
   `RPF_ASSERT_NEXT(a_found_shows, clock, reset, result.done && result.found, rsp_valid_ff)

endmodule
